// File: design/hslp_pkg.sv
// Shared types, constants and helper functions for the HTTP status line parser.
`default_nettype none
package hslp_pkg;

    // A version number fails the line once its value reaches this limit.
    localparam int unsigned VERSION_LIMIT = 65536;
    localparam logic [19:0] VERSION_LIMIT_W = 20'(VERSION_LIMIT);
    localparam logic [15:0] STATUS_MAX = 16'hFFFF;

    // Parse phase codes.
    localparam logic [3:0] PH_PREFIX0     = 4'd0;
    localparam logic [3:0] PH_PREFIX1     = 4'd1;
    localparam logic [3:0] PH_PREFIX2     = 4'd2;
    localparam logic [3:0] PH_PREFIX3     = 4'd3;
    localparam logic [3:0] PH_PREFIX4     = 4'd4;
    localparam logic [3:0] PH_MAJOR_FIRST = 4'd5;
    localparam logic [3:0] PH_MAJOR       = 4'd6;
    localparam logic [3:0] PH_MINOR       = 4'd7;
    localparam logic [3:0] PH_STATUS      = 4'd8;
    localparam logic [3:0] PH_OK          = 4'd9;
    localparam logic [3:0] PH_FAIL        = 4'd10;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UZ   = 8'h5A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    // Lower-case prefix "http/".
    localparam logic [7:0] PREFIX_TEXT [5] = '{8'h68, 8'h74, 8'h74, 8'h70, 8'h2F};

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        parse_ok;
        logic [15:0] version_major;
        logic [15:0] version_minor;
        logic [15:0] status_code;
    } t_out_item;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b inside {[CHAR_UA:CHAR_UZ]}) begin
            return b + CASE_DIFF;
        end
        return b;
    endfunction

    // acc * 10 + digit, wide enough that no carry is lost.
    function automatic logic [19:0] mul10_add(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] a;
        a = {4'b0, acc};
        return (a << 3) + (a << 1) + {16'b0, d};
    endfunction

endpackage
`default_nettype wire

// File: design/http_status_line_parser.sv
// Top level of the HTTP status line parser: input register, parse step, result register.
//
// Usage: bytes of one status line enter on the input channel (i_in_valid,
// i_in_data, o_in_stall); the final byte of a line has last_byte set. Each
// line gives exactly one result on the output channel (o_out_valid,
// o_out_data, i_out_stall), produced by its final byte. A failed parse
// reports parse_ok low with all numbers zero.
// Throughput is one byte per cycle while no final byte waits on a stalled
// output. A byte taken on the input is registered in the input register,
// the parse step runs on the registered byte, and the result of a final
// byte is registered in the result register before it is offered.
// The parse step is a compare plus one multiply-by-ten accumulate on 16-bit
// values.
// When the receiver stalls with a result waiting, bytes that are not the
// final byte of a line keep flowing; a final byte waits in the input
// register, and the input channel stalls until the output is free.
// Reset clears both valid flags and returns the parser to expect the first
// prefix character with all accumulated values at zero.
`default_nettype none
module http_status_line_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire hslp_pkg::t_in_item i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output hslp_pkg::t_out_item     o_out_data,
    input  wire logic               i_out_stall
);
    import hslp_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [3:0]  r_phase;
    logic [15:0] r_major;
    logic [15:0] r_minor;
    logic [15:0] r_status;

    logic [3:0]  n_phase;
    logic [15:0] n_major;
    logic [15:0] n_minor;
    logic [15:0] n_status;
    logic [19:0] mac_in;
    logic [15:0] mac_base;
    logic        b_digit;
    logic        step;
    logic        emit;
    logic        out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!r_in.last_byte || out_free);
    assign emit       = step && r_in.last_byte;
    assign o_in_stall = r_in_valid && !step;

    assign b_digit = is_digit(r_in.byte_value);

    // One accumulator serves whichever value the phase is building.
    always_comb begin
        case (r_phase)
            PH_MAJOR_FIRST, PH_MAJOR: mac_base = r_major;
            PH_MINOR:                 mac_base = r_minor;
            default:                  mac_base = r_status;
        endcase
        mac_in = mul10_add(mac_base, r_in.byte_value[3:0]);
    end

    always_comb begin
        n_phase  = r_phase;
        n_major  = r_major;
        n_minor  = r_minor;
        n_status = r_status;
        case (r_phase)
            PH_PREFIX0, PH_PREFIX1, PH_PREFIX2, PH_PREFIX3, PH_PREFIX4: begin
                if (to_lower(r_in.byte_value) == PREFIX_TEXT[r_phase[2:0]]) begin
                    n_phase = r_phase + 4'd1;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_MAJOR_FIRST: begin
                if (b_digit && (mac_in < VERSION_LIMIT_W)) begin
                    n_major = mac_in[15:0];
                    n_phase = PH_MAJOR;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_MAJOR: begin
                if (b_digit) begin
                    if (mac_in < VERSION_LIMIT_W) begin
                        n_major = mac_in[15:0];
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end else if (r_in.byte_value == CHAR_DOT) begin
                    n_phase = PH_MINOR;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_MINOR: begin
                if (b_digit) begin
                    if (mac_in < VERSION_LIMIT_W) begin
                        n_minor = mac_in[15:0];
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end else begin
                    // Any single non-digit byte is taken as the separator.
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b_digit) begin
                    n_status = (mac_in > {4'b0, STATUS_MAX}) ? STATUS_MAX : mac_in[15:0];
                end else begin
                    n_phase = PH_OK;
                end
            end
            PH_OK:   n_phase = PH_OK;
            default: n_phase = PH_FAIL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_PREFIX0;
            r_major     <= '0;
            r_minor     <= '0;
            r_status    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (step) begin
                if (r_in.last_byte) begin
                    r_phase  <= PH_PREFIX0;
                    r_major  <= '0;
                    r_minor  <= '0;
                    r_status <= '0;
                end else begin
                    r_phase  <= n_phase;
                    r_major  <= n_major;
                    r_minor  <= n_minor;
                    r_status <= n_status;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (emit) begin
            if (n_phase == PH_OK) begin
                r_out.parse_ok      <= 1'b1;
                r_out.version_major <= n_major;
                r_out.version_minor <= n_minor;
                r_out.status_code   <= n_status;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: design/hslp_checker.sv
// Port-level assertions for the HTTP status line parser, bound to the top level.
`default_nettype none
module hslp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire hslp_pkg::t_out_item o_out_data,
    input wire logic                i_out_stall
);
    import hslp_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A failed line reports all numbers as zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.parse_ok |->
            o_out_data.version_major == '0 && o_out_data.version_minor == '0 &&
            o_out_data.status_code == '0)
        else $error("failed parse with nonzero fields");

    // The input side only stalls when a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind http_status_line_parser hslp_checker u_hslp_checker (.*);
`default_nettype wire

// File: bench/tb_http_status_line_parser.sv
// Self-checking testbench for the HTTP status line parser, with predictor and random lines.
`timescale 1ns / 1ps

module tb_http_status_line_parser;
    import hslp_pkg::*;

    localparam int          BYTE_TARGET    = 1100;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam t_out_item   FAIL_RES       = '0;

    typedef struct {
        string     text;
        bit        typed;
        t_out_item want;
    } t_line_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    http_status_line_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Predictor state for the line in progress.
    logic [3:0]  line_phase;
    logic [15:0] acc_major;
    logic [15:0] acc_minor;
    logic [15:0] acc_status;

    t_out_item   pending_results[$];
    logic [7:0]  line_bytes[$];
    t_out_item   head_result;
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          stuck_cycles   = 0;
    bit          no_idle        = 1'b0;
    bit          hold_pending   = 1'b0;

    t_line_row dir_rows[$] = '{
        '{"HTTP/1.1 200 OK",          1'b1, '{1'b1, 16'd1, 16'd1, 16'd200}},
        '{"hTtP/1.0 404\n",           1'b0, FAIL_RES},
        '{"HTT",                      1'b1, FAIL_RES},
        '{"HTTP/",                    1'b1, FAIL_RES},
        '{"HTTP/1",                   1'b1, FAIL_RES},
        '{"HTTP/1.",                  1'b1, FAIL_RES},
        '{"HTTP/1.1 ",                1'b1, FAIL_RES},
        '{"HTTP/1.1 200",             1'b1, FAIL_RES},
        '{"HTTQ/1.1 200 ",            1'b1, FAIL_RES},
        '{"@TTP/1.1 200 ",            1'b1, FAIL_RES},
        '{"[TTP/1.1 200 ",            1'b1, FAIL_RES},
        '{"HTTP/.1 200 ",             1'b1, FAIL_RES},
        '{"HTTP/1:1 200 ",            1'b1, FAIL_RES},
        '{"HTTP/2. 301 ",             1'b0, FAIL_RES},
        '{"HTTP/1.1x404y",            1'b0, FAIL_RES},
        '{"HTTP/1.1  ",               1'b0, FAIL_RES},
        '{"HTTP/65535.65535 999999 ", 1'b1, '{1'b1, 16'd65535, 16'd65535, 16'd65535}},
        '{"HTTP/65536.0 200 ",        1'b1, FAIL_RES},
        '{"HTTP/1.65536 200 ",        1'b1, FAIL_RES},
        '{"HTTP/999999999.1 200 ",    1'b1, FAIL_RES},
        '{"HTTP/0.0 0 junk 123",      1'b0, FAIL_RES},
        '{"X",                        1'b1, FAIL_RES},
        '{"HTTP/00001.09\t00200 ",    1'b0, FAIL_RES},
        '{"http/1.1/200/",            1'b0, FAIL_RES}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advances the predictor by one byte; returns 1 with the line's result on a marked byte.
    function automatic bit predict_byte(input t_in_item it, output t_out_item res);
        logic [7:0]  b;
        logic [7:0]  lb;
        logic [3:0]  d;
        bit          dig;
        int unsigned v;
        b   = it.byte_value;
        lb  = (b >= CHAR_UA && b <= CHAR_UZ) ? b + CASE_DIFF : b;
        dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        d   = b[3:0];
        res = FAIL_RES;
        if (line_phase < PH_MAJOR_FIRST) begin
            line_phase = (lb == PREFIX_TEXT[line_phase]) ? line_phase + 4'd1 : PH_FAIL;
        end else if (line_phase == PH_MAJOR_FIRST || line_phase == PH_MAJOR) begin
            if (dig) begin
                v = acc_major * 10 + d;
                if (v >= VERSION_LIMIT) begin
                    line_phase = PH_FAIL;
                end else begin
                    acc_major  = v[15:0];
                    line_phase = PH_MAJOR;
                end
            end else if (line_phase == PH_MAJOR && b == CHAR_DOT) begin
                line_phase = PH_MINOR;
            end else begin
                line_phase = PH_FAIL;
            end
        end else if (line_phase == PH_MINOR) begin
            if (dig) begin
                v = acc_minor * 10 + d;
                if (v >= VERSION_LIMIT) begin
                    line_phase = PH_FAIL;
                end else begin
                    acc_minor = v[15:0];
                end
            end else begin
                // Any non-digit after the minor digits acts as the separator.
                line_phase = PH_STATUS;
            end
        end else if (line_phase == PH_STATUS) begin
            if (dig) begin
                v = acc_status * 10 + d;
                acc_status = (v > STATUS_MAX) ? STATUS_MAX : v[15:0];
            end else begin
                line_phase = PH_OK;
            end
        end else if (line_phase != PH_OK) begin
            line_phase = PH_FAIL;
        end
        if (!it.last_byte) begin
            return 1'b0;
        end
        if (line_phase == PH_OK) begin
            res = '{1'b1, acc_major, acc_minor, acc_status};
        end
        line_phase = PH_PREFIX0;
        acc_major  = '0;
        acc_minor  = '0;
        acc_status = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void push_decimal(input int unsigned value);
        string s;
        s = $sformatf("%0d", value);
        for (int i = 0; i < s.len(); i++) begin
            line_bytes.push_back(s[i]);
        end
    endfunction

    function automatic int unsigned pick_version();
        case ($urandom_range(0, 9))
            0: return 65535;
            1: return 65536;
            2: return $urandom_range(0, 999999);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c >= CHAR_ZERO && c <= CHAR_NINE);
        return c;
    endfunction

    // Mostly well-formed lines with random content; some cut short, corrupted or pure noise.
    function automatic void build_random_line();
        int         kind;
        int         n;
        int         pos;
        logic [7:0] c;
        line_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 95) begin
            n = $urandom_range(1, 8);
            repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < 5; i++) begin
            c = PREFIX_TEXT[i];
            if (i < 4 && $urandom_range(0, 1) == 1) begin
                c = c - CASE_DIFF;
            end
            line_bytes.push_back(c);
        end
        if ($urandom_range(0, 3) == 0) begin
            line_bytes.push_back(CHAR_ZERO);
        end
        push_decimal(pick_version());
        line_bytes.push_back(CHAR_DOT);
        if ($urandom_range(0, 5) != 0) begin
            if ($urandom_range(0, 3) == 0) begin
                line_bytes.push_back(CHAR_ZERO);
            end
            push_decimal(pick_version());
        end
        line_bytes.push_back(rand_non_digit());
        case ($urandom_range(0, 9))
            0: ;
            1: push_decimal(65535);
            2: push_decimal(65536);
            3: push_decimal($urandom_range(0, 99999999));
            default: push_decimal($urandom_range(100, 599));
        endcase
        line_bytes.push_back(rand_non_digit());
        repeat ($urandom_range(0, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
        if (kind >= 85) begin
            pos = $urandom_range(0, line_bytes.size() - 1);
            line_bytes[pos] = 8'($urandom_range(0, 255));
        end else if (kind >= 70) begin
            n = $urandom_range(1, line_bytes.size());
            while (line_bytes.size() > n) line_bytes.pop_back();
        end
    endfunction

    // Offers every byte of line_bytes, the final one marked, and logs the expected result.
    task automatic send_line(input bit typed, input t_out_item want);
        t_in_item  it;
        t_out_item res;
        int        gap;
        for (int i = 0; i < line_bytes.size(); i++) begin
            it.byte_value = line_bytes[i];
            it.last_byte  = (i == line_bytes.size() - 1);
            if (predict_byte(it, res)) begin
                pending_results.push_back(typed ? want : res);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= it;
            do @(posedge i_clk); while (o_in_stall);
            @(negedge i_clk);
        end
        bytes_sent += line_bytes.size();
    endtask

    initial begin
        int line_idx;
        line_phase = PH_PREFIX0;
        acc_major  = '0;
        acc_minor  = '0;
        acc_status = '0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < dir_rows.size(); r++) begin
            line_bytes.delete();
            for (int k = 0; k < dir_rows[r].text.len(); k++) begin
                line_bytes.push_back(dir_rows[r].text[k]);
            end
            send_line(dir_rows[r].typed, dir_rows[r].want);
        end

        line_idx = 0;
        while (bytes_sent < BYTE_TARGET) begin
            // A stretch of back-to-back transfers on both sides.
            no_idle = (line_idx >= 40 && line_idx < 70);
            if (line_idx == 12) begin
                hold_pending = 1'b1;
            end
            build_random_line();
            send_line(1'b0, FAIL_RES);
            line_idx++;
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("http_status_line_parser verification clean");
        end else begin
            $display("http_status_line_parser verification failed");
        end
        $finish;
    end

    // Result side: random stall before each transfer, plus one long hold-off.
    initial begin
        int stall_len;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_len    = HOLD_CYCLES;
            end else begin
                stall_len = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, parse_ok", o_out_data.parse_ok, 0);
            end else begin
                head_result = pending_results.pop_front();
                if (o_out_data.parse_ok !== head_result.parse_ok) begin
                    report_mismatch("parse_ok", o_out_data.parse_ok, head_result.parse_ok);
                end
                if (o_out_data.version_major !== head_result.version_major) begin
                    report_mismatch("version_major", o_out_data.version_major,
                                    head_result.version_major);
                end
                if (o_out_data.version_minor !== head_result.version_minor) begin
                    report_mismatch("version_minor", o_out_data.version_minor,
                                    head_result.version_minor);
                end
                if (o_out_data.status_code !== head_result.status_code) begin
                    report_mismatch("status_code", o_out_data.status_code,
                                    head_result.status_code);
                end
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("http_status_line_parser verification failed");
            $finish;
        end
    end

endmodule
